### rtl/core/dcl_pkg.sv
// Shared constants, register indexes and controller command type for the tone generator.
package dcl_pkg;

    // Default geometry of the oscillators.
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF     = 32;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_COEF  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP_A = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP_B = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_GAIN   = 8'd3;

    // Register widths and reset values.
    localparam int COEF_BITS = 17;
    localparam int STEP_BITS = 32;
    localparam int GAIN_BITS = 18;

    localparam logic [COEF_BITS-1:0] FILTER_COEF_RST  = 17'd32768;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_A_RST = 32'd11930465;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_B_RST = 32'd11954326;
    localparam logic [GAIN_BITS-1:0] DRIVE_GAIN_RST   = 18'd100000;

    // Fixed-point constants.
    localparam logic [COEF_BITS-1:0] COEF_ONE     = 17'd65536;
    localparam logic [63:0]          HALF_PI_Q28  = 64'd421657428;
    localparam logic [63:0]          FULL_SCALE_W = 64'd32767;

    // One command per sequencer step.
    typedef struct packed {
        logic start;   // advance phases, read sine A
        logic rdb;     // read sine B
        logic mul;     // sum times drive gain
        logic sat;     // scale back and clip
        logic diff;    // filter input minus accumulator
        logic prod;    // difference times coefficient
        logic acc;     // fold product into accumulator
        logic load;    // load the output sample
    } dcl_cmd_t;

endpackage

### rtl/core/dcl_ctrl.sv
// Sequencer that walks one tick through the datapath steps and owns the output valid.
module dcl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tick,
    output logic              m_tvalid,
    input  logic              m_tready,
    output dcl_pkg::dcl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDB,
        ST_MUL,
        ST_SAT,
        ST_DIFF,
        ST_PROD,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   load_ok;

    assign load_ok  = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd       = '0;
        cmd.start = (state_reg == ST_IDLE) && s_tvalid && s_tick;
        cmd.rdb   = (state_reg == ST_RDB);
        cmd.mul   = (state_reg == ST_MUL);
        cmd.sat   = (state_reg == ST_SAT);
        cmd.diff  = (state_reg == ST_DIFF);
        cmd.prod  = (state_reg == ST_PROD);
        cmd.acc   = (state_reg == ST_ACC);
        cmd.load  = (state_reg == ST_OUT) && load_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // raise the result on a load, drop it once taken
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tick) begin
                        state_reg <= ST_RDB;
                    end
                end
                ST_RDB:  state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_SAT;
                ST_SAT:  state_reg <= ST_DIFF;
                ST_DIFF: state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_ACC;
                ST_ACC:  state_reg <= ST_OUT;
                ST_OUT: begin
                    if (load_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/dcl_datapath.sv
// Oscillators, sine ROM, overdrive clip and one-pole lowpass, stepped by the sequencer.
module dcl_datapath #(
    parameter int SINE_ADDR_BITS = dcl_pkg::SINE_ADDR_BITS_DEF,
    parameter int PHASE_BITS     = dcl_pkg::PHASE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dcl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dcl_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  dcl_pkg::dcl_cmd_t                   cmd,
    output logic signed [15:0]                  sample
);

    localparam int SINE_LEN = 1 << SINE_ADDR_BITS;
    localparam int QSHIFT   = SINE_ADDR_BITS - 2;
    localparam int QUARTER  = 1 << QSHIFT;

    typedef logic signed [15:0] rom_t [SINE_LEN];

    // sin(pi/2 * r / QUARTER) scaled to full scale, Taylor series in Q28
    function automatic logic signed [15:0] quarter_sine(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        x   = (r * dcl_pkg::HALF_PI_Q28) >> QSHIFT;
        x2  = (x * x) >> 28;
        pos = x;
        t   = ((x * x2) >> 28) / 6;
        neg = t;
        t   = ((t * x2) >> 28) / 20;
        pos = pos + t;
        t   = ((t * x2) >> 28) / 42;
        neg = neg + t;
        t   = ((t * x2) >> 28) / 72;
        pos = pos + t;
        t   = ((t * x2) >> 28) / 110;
        neg = neg + t;
        t   = ((t * x2) >> 28) / 156;
        pos = pos + t;
        t   = ((t * x2) >> 28) / 210;
        neg = neg + t;
        if (neg >= pos) begin
            v = 64'd0;
        end else begin
            v = ((pos - neg) * dcl_pkg::FULL_SCALE_W + (64'd1 << 27)) >> 28;
            if (v > dcl_pkg::FULL_SCALE_W) begin
                v = dcl_pkg::FULL_SCALE_W;
            end
        end
        return signed'(v[15:0]);
    endfunction

    // full table from the quarter wave by symmetry
    function automatic rom_t build_rom();
        rom_t                rom;
        logic [63:0]         r;
        logic [1:0]          quad;
        logic signed [15:0]  v;
        for (int k = 0; k < SINE_LEN; k++) begin
            quad = 2'((k >> QSHIFT) & 3);
            r    = 64'(k & (QUARTER - 1));
            v    = quad[0] ? quarter_sine(64'(QUARTER) - r) : quarter_sine(r);
            rom[k] = quad[1] ? -v : v;
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration
    logic [dcl_pkg::COEF_BITS-1:0] coef_reg;
    logic [dcl_pkg::STEP_BITS-1:0] step_a_reg;
    logic [dcl_pkg::STEP_BITS-1:0] step_b_reg;
    logic [dcl_pkg::GAIN_BITS-1:0] gain_reg;

    // state
    logic [PHASE_BITS-1:0] phase_a_reg, phase_a_next;
    logic [PHASE_BITS-1:0] phase_b_reg, phase_b_next;
    logic signed [31:0]    acc_reg, acc_next;

    // payload
    logic signed [15:0] rom_q_reg;
    logic signed [15:0] sa_reg;
    logic signed [35:0] drive_reg, drive_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [15:0] sample_reg, sample_next;

    logic signed [16:0]                  sine_sum;
    logic signed [dcl_pkg::GAIN_BITS:0]  gain_s;
    logic signed [20:0]                  drive_hi;
    logic signed [20:0]                  xq;
    logic                                drive_rnd;
    logic [dcl_pkg::COEF_BITS-1:0]       coef_eff;
    logic signed [dcl_pkg::COEF_BITS:0]  coef_s;
    logic signed [34:0]                  acc_sum;
    logic                                prod_rnd;
    logic                                acc_rnd;

    assign phase_a_next = phase_a_reg + step_a_reg[PHASE_BITS-1:0];
    assign phase_b_next = phase_b_reg + step_b_reg[PHASE_BITS-1:0];

    // overdrive
    assign sine_sum   = {sa_reg[15], sa_reg} + {rom_q_reg[15], rom_q_reg};
    assign gain_s     = $signed({1'b0, gain_reg});
    assign drive_next = sine_sum * gain_s;

    // truncate toward zero: floor plus one where negative with a fraction
    assign drive_hi  = drive_reg[35:15];
    assign drive_rnd = drive_reg[35] && (drive_reg[14:0] != 15'd0);
    assign xq        = drive_hi + $signed({20'd0, drive_rnd});

    always_comb begin
        if (xq > 21'sd32767) begin
            x_next = 16'sd32767;
        end else if (xq < -21'sd32767) begin
            x_next = -16'sd32767;
        end else begin
            x_next = xq[15:0];
        end
    end

    // lowpass
    assign diff_next = $signed({x_reg[15], x_reg, 16'd0}) - $signed({acc_reg[31], acc_reg});
    assign coef_eff  = coef_reg[dcl_pkg::COEF_BITS-1] ? dcl_pkg::COEF_ONE : coef_reg;
    assign coef_s    = $signed({1'b0, coef_eff});
    assign prod_next = diff_reg * coef_s;

    assign prod_rnd = prod_reg[50] && (prod_reg[15:0] != 16'd0);
    assign acc_sum  = prod_reg[50:16] + {{3{acc_reg[31]}}, acc_reg}
                      + $signed({34'd0, prod_rnd});
    assign acc_next = acc_sum[31:0];

    assign acc_rnd     = acc_reg[31] && (acc_reg[15:0] != 16'd0);
    assign sample_next = acc_reg[31:16] + $signed({15'd0, acc_rnd});

    assign sample = sample_reg;

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg    <= dcl_pkg::FILTER_COEF_RST;
            step_a_reg  <= dcl_pkg::PHASE_STEP_A_RST;
            step_b_reg  <= dcl_pkg::PHASE_STEP_B_RST;
            gain_reg    <= dcl_pkg::DRIVE_GAIN_RST;
            phase_a_reg <= '0;
            phase_b_reg <= {1'b1, {(PHASE_BITS-1){1'b0}}};
            acc_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    dcl_pkg::REG_FILTER_COEF:  coef_reg   <= cfg_data[dcl_pkg::COEF_BITS-1:0];
                    dcl_pkg::REG_PHASE_STEP_A: step_a_reg <= cfg_data[dcl_pkg::STEP_BITS-1:0];
                    dcl_pkg::REG_PHASE_STEP_B: step_b_reg <= cfg_data[dcl_pkg::STEP_BITS-1:0];
                    dcl_pkg::REG_DRIVE_GAIN:   gain_reg   <= cfg_data[dcl_pkg::GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.start) begin
                phase_a_reg <= phase_a_next;
                phase_b_reg <= phase_b_next;
            end
            if (cmd.acc) begin
                acc_reg <= acc_next;
            end
        end
    end

    // ROM reads and pipeline payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rom_q_reg <= SINE_ROM[phase_a_next[PHASE_BITS-1 -: SINE_ADDR_BITS]];
        end
        if (cmd.rdb) begin
            sa_reg    <= rom_q_reg;
            rom_q_reg <= SINE_ROM[phase_b_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]];
        end
        if (cmd.mul) begin
            drive_reg <= drive_next;
        end
        if (cmd.sat) begin
            x_reg <= x_next;
        end
        if (cmd.diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.prod) begin
            prod_reg <= prod_next;
        end
        if (cmd.load) begin
            sample_reg <= sample_next;
        end
    end

endmodule

### rtl/core/dual_oscillator_clip_lowpass.sv
// Top level of the two-oscillator tone generator with overdrive clip and one-pole lowpass.
//
// Every transaction on the s_ side carrying tick = 1 yields one signed 16-bit sample on the
// m_ side; a transaction with tick = 0 is taken and changes nothing. Per tick both phase
// accumulators advance by their steps, their top SINE_ADDR_BITS bits address a Q1.15 sine
// ROM, the sum of the two sines is multiplied by drive_gain, scaled by 2^-15 toward zero and
// clipped to +-32767, and the result drives acc += (x - acc) * coef with a Q1.16 coefficient
// (values above 1.0 act as 1.0) and a Q16.16 accumulator; the sample is the accumulator's
// integer part, truncated toward zero. After acceptance, the block is not ready again until
// the sequencer has stepped through the single-port ROM (one read per oscillator) and
// the two registered multipliers of the overdrive and the filter.
// The result sits in an output register, so the next tick is taken while it waits; if it is
// still untaken when the next sample is done, the block holds until m_tready. The sine ROM
// is computed at elaboration. Configuration writes are always taken and should be made only
// while the block is idle; indexes beyond drive_gain are ignored.
module dual_oscillator_clip_lowpass #(
    parameter int SINE_ADDR_BITS = dcl_pkg::SINE_ADDR_BITS_DEF,  // 6 to 14
    parameter int PHASE_BITS     = dcl_pkg::PHASE_BITS_DEF       // 16 to 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] tick, [7:1] zero
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] sample (signed)
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dcl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    dcl_pkg::dcl_cmd_t  cmd;
    logic signed [15:0] sample;

    // configuration is never back-pressured
    assign cfg_ready = 1'b1;

    dcl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tick   (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dcl_datapath #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .PHASE_BITS     (PHASE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sample    (sample)
    );

    assign m_tdata = sample;

endmodule

### rtl/core/dcl_checker.sv
// Port-level assertions for the tone generator, bound to its top level.
module dcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_ready
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a tick starts a multi-cycle computation, so input is closed next cycle
    a_busy_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[0] |=> !s_tready)
        else $error("input accepted while computing a sample");

    // clipping and the filter keep the sample off the most negative code
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata != 16'h8000)
        else $error("sample outside +-32767");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind dual_oscillator_clip_lowpass dcl_checker u_dcl_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-oscillator tone generator with overdrive clip and lowpass.
module testbench;

    // Geometry of the instance under test (default parameters).
    localparam int SINE_BITS = dcl_pkg::SINE_ADDR_BITS_DEF;
    localparam int PHASE_W   = dcl_pkg::PHASE_BITS_DEF;
    localparam int SINE_LEN  = 1 << SINE_BITS;
    localparam int SINE_QTR  = SINE_LEN / 4;
    localparam int IDX_W     = dcl_pkg::CFG_INDEX_BITS;
    localparam int DATA_W    = dcl_pkg::CFG_DATA_BITS;

    // Fixed-point constants of the tone path.
    localparam longint unsigned HALF_PI_Q = 64'd421657428;  // pi/2 in Q28
    localparam longint          CLIP_MAX  = 32767;
    localparam longint          UNITY     = 65536;          // 1.0 in Q1.16 and Q16.16

    // First index that addresses no register.
    localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = IDX_W'(dcl_pkg::REG_DRIVE_GAIN + 1);

    // Leave ample margin after a tick in the sequencer before reconfiguring.
    localparam int SETTLE_CYCLES = 24;
    // Cycles without any transaction before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [0] tick, [7:1] zero
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;          // [15:0] sample (signed)
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]  cfg_data  = '0;

    // Shadow registers of the block's configuration.
    logic [dcl_pkg::COEF_BITS-1:0] coef_q;
    logic [dcl_pkg::STEP_BITS-1:0] step_a_q;
    logic [dcl_pkg::STEP_BITS-1:0] step_b_q;
    logic [dcl_pkg::GAIN_BITS-1:0] gain_q;

    // Predicted oscillator and filter state.
    logic [PHASE_W-1:0]   phase_a_q;
    logic [PHASE_W-1:0]   phase_b_q;
    longint               acc_q;
    int                   sine_tab [SINE_LEN];

    logic [15:0]          expected_samples [$];
    int                   src_idle_pct  = 0;
    int                   sink_idle_pct = 0;
    int                   mismatches    = 0;
    int                   idle_cycles   = 0;

    dual_oscillator_clip_lowpass uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave sine by an eight-term Taylor series in Q28, rounded to full scale.
    function automatic int quarter_sine(input int unsigned r);
        longint unsigned x, x2, term, pos, neg, v;
        x    = (64'(r) * HALF_PI_Q) / SINE_QTR;
        x2   = (x * x) >> 28;
        term = x;
        pos  = x;
        neg  = 0;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 28) / 64'(2 * n * (2 * n + 1));
            if (n % 2) neg += term;
            else pos += term;
        end
        if (neg >= pos) return 0;
        v = ((pos - neg) * 64'd32767 + (64'd1 << 27)) >> 28;
        if (v > 64'd32767) v = 64'd32767;
        return int'(v);
    endfunction

    // Advance both oscillators by one tick and return the filtered sample.
    function automatic logic [15:0] advance_tone();
        longint drive, x, coef, diff, level;
        phase_a_q = phase_a_q + step_a_q;
        phase_b_q = phase_b_q + step_b_q;
        drive = longint'(sine_tab[phase_a_q >> (PHASE_W - SINE_BITS)] +
                         sine_tab[phase_b_q >> (PHASE_W - SINE_BITS)]) * longint'(gain_q);
        // signed division truncates toward zero, as the overdrive scaling wants
        x = drive / 32768;
        if (x > CLIP_MAX) x = CLIP_MAX;
        if (x < -CLIP_MAX) x = -CLIP_MAX;
        // a coefficient above one saturates at one
        coef = longint'(coef_q);
        if (coef > UNITY) coef = UNITY;
        diff  = x * UNITY - acc_q;
        acc_q = acc_q + (diff * coef) / UNITY;
        level = acc_q / UNITY;
        return level[15:0];
    endfunction

    // Offer one input transaction, idling beforehand at the sender's rate, and record
    // the expected sample once it is accepted. Leave tvalid high so that a following
    // item can go back to back.
    task automatic send_item(input logic tick);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // a tick-low transaction is taken and changes nothing
        if (tick) expected_samples.push_back(advance_tone());
    endtask

    // Drop tvalid after the last item of a run.
    task automatic stop_input();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for every outstanding sample, then let the sequencer run dry.
    task automatic settle();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it, masked to its width; unused indexes do nothing.
    task automatic write_reg(input logic [IDX_W-1:0]  idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            dcl_pkg::REG_FILTER_COEF:  coef_q   = data[dcl_pkg::COEF_BITS-1:0];
            dcl_pkg::REG_PHASE_STEP_A: step_a_q = data[dcl_pkg::STEP_BITS-1:0];
            dcl_pkg::REG_PHASE_STEP_B: step_b_q = data[dcl_pkg::STEP_BITS-1:0];
            dcl_pkg::REG_DRIVE_GAIN:   gain_q   = data[dcl_pkg::GAIN_BITS-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Send a run of ticks with the odd tick-low transaction mixed in as noise.
    task automatic send_burst(input int n_ticks);
        int sent;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(99) < 8) begin
                send_item(1'b0);
            end else begin
                send_item(1'b1);
                sent++;
            end
        end
        stop_input();
    endtask

    function automatic logic [31:0] random_step();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(50_000_000);
            default: return $urandom();
        endcase
    endfunction

    // Reset values straight out of reset, tick low included.
    task automatic test_reset_state();
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b1);
        stop_input();
        settle();
    endtask

    // Coefficient zero freezes the filter; one passes the clipped sum; a wide write
    // lands above one and must act as one.
    task automatic test_filter_coef_extremes();
        logic [31:0] coefs [4];
        coefs = '{32'd0, 32'd655, 32'd65536, 32'hFFFF_FFFF};
        foreach (coefs[i]) begin
            write_reg(dcl_pkg::REG_FILTER_COEF, coefs[i]);
            send_item(1'b1);
            send_item(1'b1);
            stop_input();
            settle();
        end
    endtask

    // No gain, full gain into hard clipping, and a wide write that masks down to a small gain.
    task automatic test_drive_gain_extremes();
        logic [31:0] gains [3];
        gains = '{32'd0, 32'd262143, 32'hFFFC_0005};
        write_reg(dcl_pkg::REG_FILTER_COEF, 32'd65536);
        foreach (gains[i]) begin
            write_reg(dcl_pkg::REG_DRIVE_GAIN, gains[i]);
            send_item(1'b1);
            send_item(1'b1);
            stop_input();
            settle();
        end
    endtask

    // Frozen oscillator against one stepping backwards by the smallest amount, then swapped.
    task automatic test_phase_step_extremes();
        write_reg(dcl_pkg::REG_DRIVE_GAIN, 32'd3);
        write_reg(dcl_pkg::REG_PHASE_STEP_A, 32'd0);
        write_reg(dcl_pkg::REG_PHASE_STEP_B, 32'hFFFF_FFFF);
        send_item(1'b1);
        send_item(1'b1);
        stop_input();
        settle();
        write_reg(dcl_pkg::REG_PHASE_STEP_A, 32'hFFFF_FFFF);
        write_reg(dcl_pkg::REG_PHASE_STEP_B, 32'd0);
        send_item(1'b1);
        send_item(1'b1);
        stop_input();
        settle();
    endtask

    // Writes beyond the last register must leave the configuration alone.
    task automatic test_unused_index();
        write_reg(REG_UNUSED_FIRST, 32'hFFFF_FFFF);
        write_reg({IDX_W{1'b1}}, 32'd0);
        send_item(1'b1);
        send_item(1'b1);
        stop_input();
        settle();
    endtask

    // Bursts of ticks, each under a fresh random configuration.
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_ticks);
        int          done;
        int          burst;
        logic [31:0] coef;
        logic [31:0] gain;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        done          = 0;
        while (done < n_ticks) begin
            settle();
            case ($urandom_range(9))
                0:       coef = 32'd0;
                1:       coef = 32'd655;
                2:       coef = 32'd65536;
                3:       coef = $urandom_range(131071, 65537);
                4:       coef = $urandom();
                default: coef = $urandom_range(65536, 655);
            endcase
            case ($urandom_range(7))
                0:       gain = 32'd0;
                1:       gain = 32'd262143;
                2:       gain = $urandom();
                3:       gain = $urandom_range(200);
                default: gain = $urandom_range(262143);
            endcase
            write_reg(dcl_pkg::REG_FILTER_COEF, coef);
            write_reg(dcl_pkg::REG_PHASE_STEP_A, random_step());
            write_reg(dcl_pkg::REG_PHASE_STEP_B, random_step());
            write_reg(dcl_pkg::REG_DRIVE_GAIN, gain);
            if ($urandom_range(3) == 0)
                write_reg(IDX_W'($urandom_range(2 ** IDX_W - 1, REG_UNUSED_FIRST)), $urandom());
            burst = $urandom_range(70, 20);
            send_burst(burst);
            done += burst;
        end
        settle();
    endtask

    // Receiver: stall at random at the current rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare every result transaction with the oldest outstanding prediction.
    always @(posedge aclk) begin : check_samples
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected sample %0d", $signed(m_tdata));
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata !== want) begin
                    if (mismatches < MAX_REPORTS)
                        $display("sample mismatch: expected %0d, got %0d",
                                 $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run once no transaction of any kind has happened for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : run
        int unsigned quad;
        int unsigned r;
        int          v;
        // Build the sine table with quadrant symmetry.
        for (int k = 0; k < SINE_LEN; k++) begin
            quad = k / SINE_QTR;
            r    = k % SINE_QTR;
            v    = (quad % 2) ? quarter_sine(SINE_QTR - r) : quarter_sine(r);
            sine_tab[k] = (quad >= 2) ? -v : v;
        end
        // Initialise the predictor to the block's reset state.
        coef_q    = dcl_pkg::FILTER_COEF_RST;
        step_a_q  = dcl_pkg::PHASE_STEP_A_RST;
        step_b_q  = dcl_pkg::PHASE_STEP_B_RST;
        gain_q    = dcl_pkg::DRIVE_GAIN_RST;
        phase_a_q = '0;
        phase_b_q = {1'b1, {(PHASE_W - 1){1'b0}}};
        acc_q     = 0;

        src_idle_pct  = 7;
        sink_idle_pct = 68;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_filter_coef_extremes();
        test_drive_gain_extremes();
        test_phase_step_extremes();
        test_unused_index();
        test_random_traffic(7, 68, 390);
        test_random_traffic(68, 7, 390);
        test_random_traffic(0, 0, 390);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/dcl_pkg.sv
rtl/core/dcl_ctrl.sv
rtl/core/dcl_datapath.sv
rtl/core/dual_oscillator_clip_lowpass.sv
rtl/core/dcl_checker.sv
tb/sv/testbench.sv
